@@ rtl/prtb_pkg.sv @@
// shared types and constants for the plate row transition bounds block
package prtb_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned ROW_W = 10;
  localparam int unsigned THR_W = 10;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [THR_W-1:0] UPPER_THR_RESET = 10'd6;
  localparam logic [THR_W-1:0] LOWER_THR_RESET = 10'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER_THR = 1'b0,
    CFG_LOWER_THR = 1'b1
  } cfg_reg_e;

  // registered input transaction
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row_index;
    logic             bottom_pass;
    logic             row_start;
    logic             row_end;
    logic             frame_start;
  } in_item_t;

  // control from the top level to the row counter
  typedef struct packed {
    logic take;
    logic restart;
    logic row_end;
  } cnt_ctrl_t;

  // row counts including the pixel being taken
  typedef struct packed {
    logic [CNT_W-1:0] rise;
    logic [CNT_W-1:0] fall;
  } cnt_stat_t;

endpackage

@@ rtl/plate_row_transition_bounds_top.sv @@
// Plate row transition bounds: one pixel per transaction, one result per row end.
// Each accepted pixel is registered, then processed together with the row counters and the
// bound registers, so a pixel can be accepted in every clock cycle unless the input stalls;
// the row's last pixel passes through the input register and then the result register,
// which drives out_valid_o. Throughput is one pixel per cycle; the
// input stalls only while a row-end result is blocked by out_stall_i. Within a
// row, every SAMPLE_STEP-th column is compared with the pixel SAMPLE_STEP columns back; exact
// 0-to-255 and 255-to-0 steps are counted, saturating at 511. At row end the selected pass
// threshold sets or clears the upper or lower bound; frame_start clears both bounds.
module plate_row_transition_bounds_top
  import prtb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_STEP = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [THR_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_i,
  input  logic [ROW_W-1:0]     row_index_i,
  input  logic                 bottom_pass_i,
  input  logic                 row_start_i,
  input  logic                 row_end_i,
  input  logic                 frame_start_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [ROW_W-1:0]     upper_row_o,
  output logic                 upper_found_o,
  output logic [ROW_W-1:0]     lower_row_o,
  output logic                 lower_found_o,
  output logic [CNT_W-1:0]     rising_count_o,
  output logic [CNT_W-1:0]     falling_count_o
);

  logic [THR_W-1:0] upper_thr_q, lower_thr_q;
  in_item_t         s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             in_accept, out_free, proc;
  cnt_ctrl_t        cnt_ctrl;
  cnt_stat_t        cnt_stat;

  logic             up_found_q, up_found_d, lo_found_q, lo_found_d;
  logic [ROW_W-1:0] up_row_q, up_row_d, lo_row_q, lo_row_d;
  logic             sel_found;
  logic [ROW_W-1:0] sel_row;
  logic [THR_W-1:0] thr;
  logic             both_ge, both_lt;

  logic             out_valid_q;
  logic [ROW_W-1:0] res_up_row_q, res_lo_row_q;
  logic             res_up_found_q, res_lo_found_q;
  logic [CNT_W-1:0] res_rise_q, res_fall_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_thr_q <= UPPER_THR_RESET;
      lower_thr_q <= LOWER_THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_UPPER_THR: upper_thr_q <= cfg_data_i;
        CFG_LOWER_THR: lower_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: only a row-end transaction needs a free result slot
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = s1_valid_q && (!s1_q.row_end || out_free);
  assign in_stall_o = s1_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept)  s1_valid_d = 1'b1;
    else if (proc)  s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.pixel       <= pixel_i;
      s1_q.row_index   <= row_index_i;
      s1_q.bottom_pass <= bottom_pass_i;
      s1_q.row_start   <= row_start_i;
      s1_q.row_end     <= row_end_i;
      s1_q.frame_start <= frame_start_i;
    end
  end

  assign cnt_ctrl.take    = proc;
  assign cnt_ctrl.restart = s1_q.row_start || s1_q.frame_start;
  assign cnt_ctrl.row_end = s1_q.row_end;

  prtb_row_counter #(
    .MAX_WIDTH  (MAX_WIDTH),
    .SAMPLE_STEP(SAMPLE_STEP)
  ) u_row_counter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cnt_ctrl),
    .pixel_i(s1_q.pixel),
    .stat_o (cnt_stat)
  );

  // bound rule for the pass selected by bottom_pass
  always_comb begin
    up_found_d = s1_q.frame_start ? 1'b0 : up_found_q;
    up_row_d   = s1_q.frame_start ? '0   : up_row_q;
    lo_found_d = s1_q.frame_start ? 1'b0 : lo_found_q;
    lo_row_d   = s1_q.frame_start ? '0   : lo_row_q;

    thr       = s1_q.bottom_pass ? lower_thr_q : upper_thr_q;
    sel_found = s1_q.bottom_pass ? lo_found_d : up_found_d;
    sel_row   = s1_q.bottom_pass ? lo_row_d : up_row_d;
    both_ge   = ({1'b0, cnt_stat.rise} >= thr) && ({1'b0, cnt_stat.fall} >= thr);
    both_lt   = ({1'b0, cnt_stat.rise} < thr) && ({1'b0, cnt_stat.fall} < thr);

    if (s1_q.row_end) begin
      priority if (both_ge && !sel_found) begin
        if (s1_q.bottom_pass) begin
          lo_found_d = 1'b1;
          lo_row_d   = s1_q.row_index;
        end else begin
          up_found_d = 1'b1;
          up_row_d   = s1_q.row_index;
        end
      end else if (both_lt && sel_found && sel_row != '0) begin
        if (s1_q.bottom_pass) begin
          lo_found_d = 1'b0;
          lo_row_d   = '0;
        end else begin
          up_found_d = 1'b0;
          up_row_d   = '0;
        end
      end else begin
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_found_q <= 1'b0;
      up_row_q   <= '0;
      lo_found_q <= 1'b0;
      lo_row_q   <= '0;
    end else if (proc) begin
      up_found_q <= up_found_d;
      up_row_q   <= up_row_d;
      lo_found_q <= lo_found_d;
      lo_row_q   <= lo_row_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && s1_q.row_end) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && s1_q.row_end) begin
      res_up_row_q   <= up_row_d;
      res_up_found_q <= up_found_d;
      res_lo_row_q   <= lo_row_d;
      res_lo_found_q <= lo_found_d;
      res_rise_q     <= cnt_stat.rise;
      res_fall_q     <= cnt_stat.fall;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign upper_row_o     = res_up_row_q;
  assign upper_found_o   = res_up_found_q;
  assign lower_row_o     = res_lo_row_q;
  assign lower_found_o   = res_lo_found_q;
  assign rising_count_o  = res_rise_q;
  assign falling_count_o = res_fall_q;

  // a bound that is not held keeps a zero row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !up_found_q |-> up_row_q == '0)
    else $error("upper bound row not zero while not held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !lo_found_q |-> lo_row_q == '0)
    else $error("lower bound row not zero while not held");

  // a processed row end always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_q.row_end |=> out_valid_q)
    else $error("row-end transaction produced no result");

  // stall only with a pending row end behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_q.row_end && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

endmodule

@@ rtl/prtb_row_counter.sv @@
// per-row sampling history and transition counters
module prtb_row_counter
  import prtb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 1024,
  parameter int unsigned SAMPLE_STEP = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_ctrl_t        ctrl_i,
  input  logic [PIX_W-1:0] pixel_i,
  output cnt_stat_t        stat_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned PW = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_WIDTH);
  localparam logic [CW-1:0] STEP_COL = CW'(SAMPLE_STEP);
  localparam logic [PW-1:0] PHASE_LAST = PW'(SAMPLE_STEP - 1);

  logic [CW-1:0]    col_q, col_d, col_eff;
  logic [PW-1:0]    phase_q, phase_d, phase_eff;
  logic [CNT_W-1:0] rise_q, rise_d, rise_eff, rise_new;
  logic [CNT_W-1:0] fall_q, fall_d, fall_eff, fall_new;
  logic [PIX_W-1:0] hist_q [SAMPLE_STEP];
  logic [PIX_W-1:0] oldest;
  logic             active, compare;

  always_comb begin
    col_eff   = ctrl_i.restart ? '0 : col_q;
    phase_eff = ctrl_i.restart ? '0 : phase_q;
    rise_eff  = ctrl_i.restart ? '0 : rise_q;
    fall_eff  = ctrl_i.restart ? '0 : fall_q;
    oldest    = hist_q[SAMPLE_STEP-1];

    // columns past the maximum width are ignored
    active  = col_eff < COL_LIMIT;
    compare = active && (phase_eff == '0) && (col_eff >= STEP_COL);

    rise_new = rise_eff;
    fall_new = fall_eff;
    if (compare && oldest == PIX_BLACK && pixel_i == PIX_WHITE) begin
      if (rise_eff != CNT_MAX) rise_new = rise_eff + CNT_W'(1);
    end else if (compare && oldest == PIX_WHITE && pixel_i == PIX_BLACK) begin
      if (fall_eff != CNT_MAX) fall_new = fall_eff + CNT_W'(1);
    end

    if (ctrl_i.row_end) begin
      col_d   = '0;
      phase_d = '0;
      rise_d  = '0;
      fall_d  = '0;
    end else begin
      col_d   = active ? col_eff + CW'(1) : col_eff;
      phase_d = phase_eff;
      if (active) phase_d = (phase_eff == PHASE_LAST) ? '0 : phase_eff + PW'(1);
      rise_d  = rise_new;
      fall_d  = fall_new;
    end
  end

  assign stat_o.rise = rise_new;
  assign stat_o.fall = fall_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= '0;
      rise_q  <= '0;
      fall_q  <= '0;
    end else if (ctrl_i.take) begin
      col_q   <= col_d;
      phase_q <= phase_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
    end
  end

  // history entries are only read once a full step of the row has been seen
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && active) begin
      hist_q[0] <= pixel_i;
      for (int k = 1; k < SAMPLE_STEP; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

endmodule
